// ===== sv/glm_pkg.sv =====
// package for the grid local minima and upper sum block
// types, widths and constants shared by the front, the back and the top level
// no dependencies
package glm_pkg;

    localparam int MAX_SIDE_DEF   = 64;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int CFG_W          = 7;
    localparam int SIDE_RESET     = 10;
    localparam int COUNT_W        = 13;
    localparam int SUM_W          = 20;
    localparam int QUEUE_DEPTH    = 4;

    // position flags worked out by the front for each pixel
    typedef struct packed {
        logic row_first;   // top row, nothing above
        logic row_early;   // top two rows, nothing two above
        logic upper;       // column beyond row
        logic col_first;
        logic col_last;
        logic frame_last;
    } glm_flags_t;

    localparam int FLAGS_W = $bits(glm_flags_t);

    typedef struct packed {
        logic flushing;
        logic res_load;
    } glm_status_t;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== sv/glm_ram.sv =====
// generic single write, single read memory with registered read data
// read data holds while no read is issued; depends on glm_pkg
module glm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [glm_pkg::addr_bits(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [glm_pkg::addr_bits(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                       rdata
);
    import glm_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/glm_queue.sv =====
// short first-in first-out queue between the front and the back
// register array with read and write pointers; depends on glm_pkg
module glm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = glm_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import glm_pkg::*;

    localparam int PTR_W = addr_bits(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push;
    logic             pop;

    assign in_ready  = (fill_reg != CNT_W'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== sv/glm_front.sv =====
// front part: side length register, raster position counters, pixel flags
// depends on glm_pkg
module glm_front #(
    parameter int MAX_SIDE   = glm_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = glm_pkg::PIXEL_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [glm_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [PIXEL_BITS-1:0]                  s_pixel,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [PIXEL_BITS-1:0]                  out_pixel,
    output logic [glm_pkg::addr_bits(MAX_SIDE)-1:0] out_col,
    output glm_pkg::glm_flags_t                    out_flags,
    output logic [$clog2(MAX_SIDE + 1)-1:0]        side,
    output logic                                   cfg_write
);
    import glm_pkg::*;

    localparam int COL_W  = addr_bits(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam logic [SIDE_W-1:0] SIDE_INIT =
        SIDE_W'((SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET);

    logic [SIDE_W-1:0] side_reg, side_next;
    logic [COL_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [SIDE_W-1:0] side_m1;
    logic              accept;
    glm_flags_t        flags;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;
    assign side      = side_reg;
    assign side_m1   = side_reg - SIDE_W'(1);

    assign s_ready   = out_ready;
    assign out_valid = s_valid;
    assign out_pixel = s_pixel;
    assign out_col   = col_reg;
    assign out_flags = flags;
    assign accept    = s_valid && out_ready;

    always_comb begin
        flags.row_first  = (row_reg == '0);
        flags.row_early  = (32'(row_reg) < 2);
        flags.upper      = (col_reg > row_reg);
        flags.col_first  = (col_reg == '0);
        flags.col_last   = (SIDE_W'(col_reg) == side_m1);
        flags.frame_last = flags.col_last && (SIDE_W'(row_reg) == side_m1);
    end

    always_comb begin
        side_next = side_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (cfg_write) begin
            // zero acts as one, anything beyond the line stores is clamped
            if (cfg_data == '0) begin
                side_next = SIDE_W'(1);
            end else if (32'(cfg_data) > MAX_SIDE) begin
                side_next = SIDE_W'(MAX_SIDE);
            end else begin
                side_next = SIDE_W'(cfg_data);
            end
            row_next = '0;
            col_next = '0;
        end else if (accept) begin
            if (flags.col_last) begin
                col_next = '0;
                row_next = flags.frame_last ? '0 : row_reg + COL_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SIDE_INIT;
            row_reg  <= '0;
            col_reg  <= '0;
        end else begin
            side_reg <= side_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

endmodule

// ===== sv/glm_back.sv =====
// back part: two line stores, neighbour window, minimum test, accumulators,
// final row sweep and result register; depends on glm_pkg and glm_ram
module glm_back #(
    parameter int MAX_SIDE   = glm_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = glm_pkg::PIXEL_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic [$clog2(MAX_SIDE + 1)-1:0]         side,
    input  logic                                    cfg_write,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [PIXEL_BITS-1:0]                   in_pixel,
    input  logic [glm_pkg::addr_bits(MAX_SIDE)-1:0] in_col,
    input  glm_pkg::glm_flags_t                     in_flags,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [glm_pkg::COUNT_W-1:0]             m_minima_count,
    output logic [glm_pkg::SUM_W-1:0]               m_upper_sum,
    output glm_pkg::glm_status_t                    status
);
    import glm_pkg::*;

    localparam int COL_W  = addr_bits(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int ADD_W  = ((PIXEL_BITS > SUM_W) ? PIXEL_BITS : SUM_W) + 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

    typedef enum logic [1:0] {ST_RUN, ST_WAIT, ST_FLUSH} state_t;

    state_t                state_reg, state_next;
    logic [COL_W-1:0]      fc_reg, fc_next;

    logic                  s2_valid_reg, s2_valid_next;
    logic                  s2_real_reg, s2_real_next;
    logic                  s2_test_reg, s2_test_next;
    logic                  s2_up_free_reg, s2_up_free_next;
    logic                  s2_down_free_reg, s2_down_free_next;
    logic                  s2_left_free_reg, s2_left_free_next;
    logic                  s2_right_free_reg, s2_right_free_next;
    logic                  s2_upper_reg, s2_upper_next;
    logic                  s2_end_reg, s2_end_next;
    logic [COL_W-1:0]      s2_col_reg, s2_col_next;
    logic [PIXEL_BITS-1:0] s2_pixel_reg, s2_pixel_next;

    logic [PIXEL_BITS-1:0] win_left_reg, win_left_next;
    logic [PIXEL_BITS-1:0] win_mid_reg, win_mid_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0]    m_count_reg, m_count_next;
    logic [SUM_W-1:0]      m_sum_reg, m_sum_next;

    logic [SIDE_W-1:0]     side_m1;
    logic                  single;
    logic                  pop;
    logic                  sweep;
    logic                  sweep_last;
    logic                  issue;
    logic [COL_W-1:0]      st1_col;
    logic                  st1_col_last;
    logic [COL_W-1:0]      a_raddr;
    logic [PIXEL_BITS-1:0] a_rdata;
    logic [PIXEL_BITS-1:0] b_rdata;
    logic                  b_we;
    logic                  hit;
    logic [COUNT_W-1:0]    count_upd;
    logic [ADD_W-1:0]      sum_wide;
    logic [SUM_W-1:0]      sum_upd;

    assign side_m1    = side - SIDE_W'(1);
    assign single     = (side == SIDE_W'(1));
    assign in_ready   = (state_reg == ST_RUN);
    assign pop        = in_ready && in_valid;
    assign sweep      = (state_reg == ST_FLUSH);
    assign sweep_last = (SIDE_W'(fc_reg) == side_m1);
    assign issue      = pop || sweep;
    assign st1_col      = pop ? in_col : fc_reg;
    assign st1_col_last = pop ? in_flags.col_last : sweep_last;
    // read one column ahead; at row end this fetches column zero of the new row above
    assign a_raddr    = st1_col_last ? '0 : st1_col + COL_W'(1);
    assign b_we       = s2_valid_reg && s2_real_reg;

    // row above the incoming pixel, overwritten by the incoming row
    glm_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_SIDE)
    ) u_newer_ram (
        .aclk  (aclk),
        .we    (pop),
        .waddr (in_col),
        .wdata (in_pixel),
        .re    (issue),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // row two above, overwritten by the row above
    glm_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_SIDE)
    ) u_older_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (s2_col_reg),
        .wdata (win_mid_reg),
        .re    (issue),
        .raddr (st1_col),
        .rdata (b_rdata)
    );

    // minimum test on the pixel of the row above
    always_comb begin
        hit = s2_test_reg
              && (s2_up_free_reg    || (win_mid_reg < b_rdata))
              && (s2_down_free_reg  || (win_mid_reg < s2_pixel_reg))
              && (s2_left_free_reg  || (win_mid_reg < win_left_reg))
              && (s2_right_free_reg || (win_mid_reg < a_rdata));
        count_upd = count_reg;
        if (hit && (count_reg != COUNT_MAX)) begin
            count_upd = count_reg + COUNT_W'(1);
        end
        sum_wide = ADD_W'(sum_reg) + ADD_W'(s2_pixel_reg);
        sum_upd  = sum_reg;
        if (s2_upper_reg) begin
            sum_upd = (sum_wide > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(sum_wide);
        end
    end

    always_comb begin
        state_next         = state_reg;
        fc_next            = fc_reg;
        s2_valid_next      = issue;
        s2_real_next       = pop;
        s2_test_next       = pop ? !in_flags.row_first : 1'b1;
        s2_up_free_next    = pop ? in_flags.row_early : single;
        s2_down_free_next  = sweep;
        s2_left_free_next  = pop ? in_flags.col_first : (fc_reg == '0);
        s2_right_free_next = st1_col_last;
        s2_upper_next      = pop && in_flags.upper;
        s2_end_next        = sweep && sweep_last;
        s2_col_next        = st1_col;
        s2_pixel_next      = in_pixel;
        win_left_next      = win_left_reg;
        win_mid_next       = win_mid_reg;
        count_next         = count_reg;
        sum_next           = sum_reg;
        m_valid_next       = m_valid_reg;
        m_count_next       = m_count_reg;
        m_sum_next         = m_sum_reg;

        unique case (state_reg)
            ST_RUN: begin
                if (pop && in_flags.frame_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // sweep only once the result slot is free
                if (!m_valid_reg) begin
                    state_next = ST_FLUSH;
                    fc_next    = '0;
                end
            end
            ST_FLUSH: begin
                fc_next = fc_reg + COL_W'(1);
                if (sweep_last) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s2_valid_reg) begin
            win_left_next = win_mid_reg;
            // a one-wide grid takes the pixel it just wrote from the stage register, not the line store
            win_mid_next  = single ? s2_pixel_reg : a_rdata;
            if (s2_end_reg) begin
                m_valid_next = 1'b1;
                m_count_next = count_upd;
                m_sum_next   = sum_upd;
                count_next   = '0;
                sum_next     = '0;
            end else begin
                count_next = count_upd;
                sum_next   = sum_upd;
            end
        end

        if (cfg_write) begin
            count_next = '0;
            sum_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            fc_reg       <= '0;
            s2_valid_reg <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fc_reg       <= fc_next;
            s2_valid_reg <= s2_valid_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            m_valid_reg  <= m_valid_next;
        end
        s2_real_reg       <= s2_real_next;
        s2_test_reg       <= s2_test_next;
        s2_up_free_reg    <= s2_up_free_next;
        s2_down_free_reg  <= s2_down_free_next;
        s2_left_free_reg  <= s2_left_free_next;
        s2_right_free_reg <= s2_right_free_next;
        s2_upper_reg      <= s2_upper_next;
        s2_end_reg        <= s2_end_next;
        s2_col_reg        <= s2_col_next;
        s2_pixel_reg      <= s2_pixel_next;
        win_left_reg      <= win_left_next;
        win_mid_reg       <= win_mid_next;
        m_count_reg       <= m_count_next;
        m_sum_reg         <= m_sum_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_minima_count  = m_count_reg;
    assign m_upper_sum     = m_sum_reg;
    assign status.flushing = sweep;
    assign status.res_load = s2_valid_reg && s2_end_reg;

endmodule

// ===== sv/grid_local_minima_and_upper_sum.sv =====
// throughput: one pixel per cycle while the queue has room; each frame adds a final-row sweep
// of the back, partly hidden by the front queue
// result: registered at the end of the final row sweep, which starts once the result slot is free
// reset: synchronous, active low; clears position, accumulators and handshakes,
// line stores keep whatever they hold and need no clearing
module grid_local_minima_and_upper_sum #(
    parameter int MAX_SIDE   = glm_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = glm_pkg::PIXEL_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // side length register write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [glm_pkg::CFG_W-1:0]   cfg_data,
    // pixel stream, raster order
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [PIXEL_BITS-1:0]       s_pixel,
    // one result item per frame
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [glm_pkg::COUNT_W-1:0] m_minima_count,
    output logic [glm_pkg::SUM_W-1:0]   m_upper_sum
);
    import glm_pkg::*;

    localparam int COL_W  = addr_bits(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    // queue item layout: flags, column, pixel
    localparam int QW     = FLAGS_W + COL_W + PIXEL_BITS;

    logic                  f_valid;
    logic                  f_ready;
    logic [PIXEL_BITS-1:0] f_pixel;
    logic [COL_W-1:0]      f_col;
    glm_flags_t            f_flags;
    logic [SIDE_W-1:0]     side;
    logic                  cfg_write;

    logic [QW-1:0]         q_in;
    logic [QW-1:0]         q_out;
    logic                  q_valid;
    logic                  q_ready;
    logic [PIXEL_BITS-1:0] q_pixel;
    logic [COL_W-1:0]      q_col;
    glm_flags_t            q_flags;

    glm_status_t           status;

    // front: register, position counters and per-pixel flags
    glm_front #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_pixel (f_pixel),
        .out_col   (f_col),
        .out_flags (f_flags),
        .side      (side),
        .cfg_write (cfg_write)
    );

    assign q_in = {f_flags, f_col, f_pixel};

    // queue keeps pixels flowing while the back sweeps the last row
    glm_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_out)
    );

    assign q_pixel = q_out[PIXEL_BITS-1:0];
    assign q_col   = q_out[PIXEL_BITS +: COL_W];
    assign q_flags = glm_flags_t'(q_out[QW-1 -: FLAGS_W]);

    // back: line stores, minimum test, sums, final row sweep, result register
    glm_back #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .side           (side),
        .cfg_write      (cfg_write),
        .in_valid       (q_valid),
        .in_ready       (q_ready),
        .in_pixel       (q_pixel),
        .in_col         (q_col),
        .in_flags       (q_flags),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_minima_count (m_minima_count),
        .m_upper_sum    (m_upper_sum),
        .status         (status)
    );

    // a result is only written into an empty result slot
    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        status.res_load |-> !m_valid)
        else $error("result loaded over a pending result");

    // no pixel leaves the queue while the last row is being swept
    a_no_pop_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        status.flushing |-> !(q_valid && q_ready))
        else $error("queue popped during final row sweep");

    // reset empties the queue and the result slot
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !q_valid))
        else $error("queue or result slot not empty after reset");

endmodule
